>>> rtl/core/spq_pkg.sv
package spq_pkg;

    // Queue depth and the widths that follow from it
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Fixed field widths of the item channels
    localparam int OP_W    = 2;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    typedef logic signed [VAL_W-1:0] t_value;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic   ins_en;
        logic   rem_en;
        t_value value;
    } t_cell_ctrl;

    // Per-cell compare results, seen by the neighbour and the controller
    typedef struct packed {
        logic keep;
        logic match;
        logic first;
        logic slot;
    } t_cell_stat;

endpackage

>>> rtl/core/spq_if.sv
interface spq_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic signed [31:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface spq_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [3:0]         position;
    logic signed [31:0] head_value;
    logic [4:0]         entry_count;
    logic               is_empty;

    modport source (output valid, output status, output position, output head_value,
                    output entry_count, output is_empty, input ready);
    modport sink   (input valid, input status, input position, input head_value,
                    input entry_count, input is_empty, output ready);
endinterface

>>> rtl/core/sorted_priority_queue.sv
// Latency: an accepted item yields its result in the output register on the next cycle.
// Throughput: one item per cycle; every cell compares and shifts in the same cycle.
// The input stalls only while a finished result waits in the output register and the sink is not ready.
// Reset (synchronous, active low) empties the queue and the output register at once;
// entry contents are not cleared and are never read beyond the entry count.
module sorted_priority_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    import spq_pkg::*;

    t_cell_ctrl              cell_ctrl;
    t_cell_stat              stat [CAPACITY];
    t_value                  data [CAPACITY];
    t_value                  next [CAPACITY];
    logic [CAPACITY-1:0]     keep_vec;
    logic [CAPACITY-1:0]     match_vec;
    logic [CAPACITY-1:0]     first_vec;
    logic [CAPACITY-1:0]     slot_vec;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    logic                    n_out_valid;
    t_status                 r_status;
    t_status                 n_status;
    logic [POS_W-1:0]        r_position;
    logic [POS_W-1:0]        n_position;
    t_value                  r_head;
    t_value                  n_head;
    logic [COUNT_W-1:0]      r_entry_count;
    logic [COUNT_W-1:0]      n_entry_count;
    logic                    r_is_empty;
    logic                    n_is_empty;

    logic                    accept;
    t_opcode                 op;
    logic                    full;
    logic                    found;
    logic [IDX_W-1:0]        ins_idx;
    logic [IDX_W-1:0]        hit_idx;

    assign accept = i_in.valid && i_in.ready;
    assign op     = t_opcode'(i_in.opcode);
    assign full   = (r_count >= CAP_CNT);
    assign found  = |match_vec;

    // Broadcast the operation to the row
    always_comb begin
        cell_ctrl.ins_en = accept && (op == OP_INSERT) && !full;
        cell_ctrl.rem_en = accept && (op == OP_REMOVE) && found;
        cell_ctrl.value  = i_in.value;
    end

    // Row of cells, each linked to its neighbours
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   left_keep;
        logic   left_match;
        t_value left_data;
        t_value right_data;

        if (g == 0) begin : g_head
            assign left_keep  = 1'b1;
            assign left_match = 1'b0;
            assign left_data  = i_in.value;
        end else begin : g_body
            assign left_keep  = stat[g-1].keep;
            assign left_match = stat[g-1].match;
            assign left_data  = data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_data = data[g];
        end else begin : g_inner
            assign right_data = data[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl),
            .i_is_head    (g == 0),
            .i_valid      (CNT_W'(g) < r_count),
            .i_left_keep  (left_keep),
            .i_left_match (left_match),
            .i_left_data  (left_data),
            .i_right_data (right_data),
            .o_stat       (stat[g]),
            .o_data       (data[g]),
            .o_next       (next[g])
        );

        assign keep_vec[g]  = stat[g].keep;
        assign match_vec[g] = stat[g].match;
        assign first_vec[g] = stat[g].first;
        assign slot_vec[g]  = stat[g].slot;
    end

    // Encode the one-hot insert slot and first match
    always_comb begin
        ins_idx = '0;
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            ins_idx = ins_idx | (slot_vec[i]  ? IDX_W'(i) : IDX_W'(0));
            hit_idx = hit_idx | (first_vec[i] ? IDX_W'(i) : IDX_W'(0));
        end
    end

    // Update the count
    always_comb begin
        priority if (cell_ctrl.ins_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (cell_ctrl.rem_en) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    // Form the result
    always_comb begin
        n_status   = ST_OK;
        n_position = '0;
        unique case (op)
            OP_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_position = POS_W'(ins_idx);
                end
            end
            OP_REMOVE, OP_FIND: begin
                if (found) begin
                    n_position = POS_W'(hit_idx);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        n_head        = (n_count != '0) ? next[0] : '0;
        n_entry_count = COUNT_W'(n_count);
        n_is_empty    = (n_count == '0);
    end

    // Hold the result until the sink takes it
    assign n_out_valid = accept || (r_out_valid && !o_out.ready);
    assign i_in.ready  = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= n_status;
            r_position    <= n_position;
            r_head        <= n_head;
            r_entry_count <= n_entry_count;
            r_is_empty    <= n_is_empty;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.position    = r_position;
    assign o_out.head_value  = r_head;
    assign o_out.entry_count = r_entry_count;
    assign o_out.is_empty    = r_is_empty;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctrl.ins_en |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the queue");

    a_keep_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((keep_vec >> 1) & ~keep_vec) == '0)
        else $error("kept cells do not form a prefix");

    a_first_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(first_vec))
        else $error("more than one first match");
`endif

endmodule

>>> rtl/core/spq_cell.sv
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic               i_is_head,
    input  logic               i_valid,
    input  logic               i_left_keep,
    input  logic               i_left_match,
    input  spq_pkg::t_value    i_left_data,
    input  spq_pkg::t_value    i_right_data,
    output spq_pkg::t_cell_stat o_stat,
    output spq_pkg::t_value    o_data,
    output spq_pkg::t_value    o_next
);
    import spq_pkg::*;

    t_value r_data;
    t_value n_data;
    logic   gt;
    logic   eq;

    // Compare the stored entry against the broadcast value
    always_comb begin
        gt           = i_valid && (r_data > i_ctrl.value);
        eq           = i_valid && (r_data == i_ctrl.value);
        o_stat.keep  = gt || (i_is_head && eq);
        o_stat.match = eq;
        o_stat.first = eq && !i_left_match;
        o_stat.slot  = !o_stat.keep && i_left_keep;
    end

    // Keep, take the new value, shift down from the left or close up from the right
    always_comb begin
        priority if (i_ctrl.ins_en && !o_stat.keep) begin
            n_data = i_left_keep ? i_ctrl.value : i_left_data;
        end else if (i_ctrl.rem_en && !gt) begin
            n_data = i_right_data;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_next = n_data;

endmodule
